@@ rtl/core/ddodo_pkg.sv @@
// Shared constants and the arctangent table for the differential-drive odometry core.
// No dependencies; imported by diff_drive_odometry_core.
package ddodo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;
  localparam int unsigned POS_WIDTH_DEF    = 40;

  // 2^64/(2*pi*1e9) and CORDIC gain reciprocal, both Q32
  localparam logic [31:0] K_BAM  = 32'd2935890503;
  localparam logic [31:0] K_GAIN = 32'd2608131497;

  // output divide by 256000 = 2^11 * 125, rounded on the magnitude
  localparam logic [63:0] DIV_HALF  = 64'd128000;
  localparam int unsigned DIV_SHIFT = 11;
  localparam logic [7:0]  DIV_ODD   = 8'd125;

  // divide by 125 as a multiply by ceil(2^38/125), then a shift by 38;
  // exact for numerators below 2^31
  localparam logic [31:0] K_DIV_RCP     = 32'd2199023256;
  localparam int unsigned DIV_RCP_SHIFT = 38;

  localparam logic [1:0] CFG_INV_WHEEL_BASE = 2'd0;
  localparam logic [1:0] CFG_MAX_DT_US      = 2'd1;

  localparam logic [23:0] INV_WHEEL_BASE_RST = 24'd168067;
  localparam logic [31:0] MAX_DT_US_RST      = 32'd1000000;

  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      5'd31: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/core/diff_drive_odometry_core.sv @@
// Differential-drive odometry core: sequencer around one shared multiplier
// and one CORDIC stage. Depends on ddodo_pkg.
//
// Usage:
//   Input channel (in_*): one word per wheel feedback sample carrying left and
//   right wheel speeds (mm/s) and a microsecond stamp. The word is taken when
//   in_tvalid and in_tready are high at a rising clk edge.
//   Output channel (out_*): one word with pose (x, y in micrometres, heading as
//   a binary angle) and twist (center speed, angular rate in mrad/s).
//   Config channel (cfg_*): always ready; index 0 writes the wheel-base
//   reciprocal, index 1 the largest accepted interval; other indexes are dropped.
//   Write config only while the core is idle.
// Operation:
//   A sample with a zero or too long interval updates the stored stamp and
//   gives no word; the core is ready again on the next cycle.
//   A valid sample runs setup with passes through the shared 32x32 multiplier
//   (wheel rate, yaw step, prescaled distance), one CORDIC iteration per cycle,
//   and for each axis the divide by 256000 (two reciprocal multiplies); then
//   out_tvalid rises. The next sample is taken only after the receiver has
//   accepted the result. One sample is worked at a time.
// Reset (synchronous, rst_n low) clears pose, stored stamp and the sequencer,
// and loads the register reset values.
// Receiver stall: the finished word holds on out_tdata and in_tready stays low
// until out_tready takes it.
module diff_drive_odometry_core #(
  parameter int unsigned CORDIC_STEPS = ddodo_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned POS_WIDTH    = ddodo_pkg::POS_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // [15:0] wheel_l, [31:16] wheel_r, [63:32] stamp_us
  output logic         out_tvalid,
  input  logic         out_tready,
  // [39:0] pos_x, [79:40] pos_y, [111:80] heading, [127:112] lin_speed,
  // [159:128] ang_speed
  output logic [159:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import ddodo_pkg::*;

  // rounded magnitude over 2^11 stays below 2^45 (rotated vector is at most 2^55)
  localparam int unsigned NUMW = 45;
  localparam int unsigned SUMW = 66;

  typedef enum logic [3:0] {
    S_IDLE, S_MW, S_MP, S_MYL, S_MYH, S_YAW, S_MDL, S_MDH, S_ROT0, S_CORD,
    S_DSET, S_QH, S_RH, S_QL, S_ACC, S_OUT
  } state_t;

  state_t state_r;

  logic [23:0] inv_r;
  logic [31:0] maxdt_r;
  logic [31:0] prev_stamp_r, dt_r;
  logic signed [15:0] vc_r;
  logic        vneg_r, dneg_r, wneg_r;
  logic [16:0] vmag_r, dmag_r;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r;
  logic [31:0] p_hi_r;
  logic [32:0] rnd_r;
  logic signed [31:0] w_r;
  logic [31:0] yaw_r, mid_r;
  logic signed [63:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic [4:0]  it_r;
  logic [NUMW-1:0] num_r;
  logic [20:0] quo_hi_r;
  logic [30:0] num_lo_r;
  logic        qneg_r, sel_y_r;
  logic [POS_WIDTH-1:0] acc_x_r, acc_y_r;
  logic        out_tvalid_r;
  logic [159:0] out_tdata_r;

  // input split
  logic signed [15:0] in_l, in_r;
  logic [31:0] in_stamp, in_dt;
  logic signed [16:0] sum_lr, dif_lr, vc17;
  logic        in_ok;

  // combinational helpers
  logic [63:0] wrnd;
  logic [31:0] wmag_c;
  logic [63:0] m_c, dth_c, mg_c, xs_c, src_mag;
  logic [32:0] mid_t;
  logic signed [63:0] x0_c, cx_s, cy_s;
  logic        quad_c;
  logic [31:0] ang_c, at_c;
  logic [20:0] qh_c;
  logic [27:0] rh_c;
  logic [NUMW-1:0] qfin_c;
  logic signed [SUMW-1:0] dq_c, acc_c, sum_c, hi_c, lo_c, sat_c;

  assign in_l     = in_tdata[15:0];
  assign in_r     = in_tdata[31:16];
  assign in_stamp = in_tdata[63:32];
  assign in_dt    = in_stamp - prev_stamp_r;
  assign in_ok    = (in_dt != 32'd0) && (in_dt <= maxdt_r);
  assign sum_lr   = 17'(in_l) + 17'(in_r);
  assign dif_lr   = 17'(in_r) - 17'(in_l);
  // truncate toward zero
  assign vc17     = (sum_lr + (sum_lr[16] ? 17'sd1 : 17'sd0)) >>> 1;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_r)
      S_MW:  begin mul_a = 32'(dmag_r); mul_b = 32'(inv_r); end
      S_MP:  begin mul_a = wmag_c;      mul_b = dt_r;       end
      S_MYL: begin mul_a = prod_r[31:0]; mul_b = K_BAM;     end
      S_MYH: begin mul_a = p_hi_r;      mul_b = K_BAM;      end
      S_YAW: begin mul_a = 32'(vmag_r); mul_b = dt_r;       end
      S_MDL: begin mul_a = prod_r[31:0]; mul_b = K_GAIN;    end
      S_MDH: begin mul_a = p_hi_r;      mul_b = K_GAIN;     end
      S_QH:  begin mul_a = 32'(num_r[NUMW-1:24]); mul_b = K_DIV_RCP; end
      S_QL:  begin mul_a = {1'b0, num_lo_r};      mul_b = K_DIV_RCP; end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end

  always_comb begin
    // rate: round magnitude, then saturate to 32 bits signed
    wrnd = (prod_r + 64'd32768) >> 16;
    if (dneg_r) begin
      wmag_c = (wrnd > 64'h8000_0000) ? 32'h8000_0000 : wrnd[31:0];
    end else begin
      wmag_c = (wrnd > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : wrnd[31:0];
    end
    // yaw step and midpoint angle
    m_c   = prod_r + 64'(rnd_r);
    dth_c = wneg_r ? (64'd0 - m_c) : m_c;
    mid_t = {yaw_r, 1'b0} + dth_c[32:0];
    // prescaled distance with guard bits, folded to the right half plane
    mg_c   = prod_r + 64'(rnd_r);
    xs_c   = mg_c << 8;
    x0_c   = vneg_r ? -$signed(xs_c) : $signed(xs_c);
    quad_c = 1'(((mid_r + 32'h4000_0000) >> 31));
    ang_c  = mid_r ^ {quad_c, 31'd0};
    // CORDIC step
    cx_s = x_r >>> it_r;
    cy_s = y_r >>> it_r;
    at_c = atan_bam(it_r);
    // divide by 125 in two halves: upper 21 bits, then remainder and lower 24
    src_mag = sel_y_r ? (y_r[63] ? 64'(-y_r) : 64'(y_r))
                      : (x_r[63] ? 64'(-x_r) : 64'(x_r));
    qh_c   = prod_r[DIV_RCP_SHIFT+20:DIV_RCP_SHIFT];
    rh_c   = 28'(num_r[NUMW-1:24]) - 28'(qh_c) * 28'(DIV_ODD);
    qfin_c = {quo_hi_r, prod_r[DIV_RCP_SHIFT+23:DIV_RCP_SHIFT]};
    dq_c   = qneg_r ? -$signed(SUMW'(qfin_c)) : $signed(SUMW'(qfin_c));
    acc_c  = sel_y_r ? SUMW'($signed(acc_y_r)) : SUMW'($signed(acc_x_r));
    sum_c  = acc_c + dq_c;
    hi_c   = $signed({{(SUMW - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}});
    lo_c   = ~hi_c;
    priority if (sum_c > hi_c) begin
      sat_c = hi_c;
    end else if (sum_c < lo_c) begin
      sat_c = lo_c;
    end else begin
      sat_c = sum_c;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    if (!rst_n) begin
      state_r      <= S_IDLE;
      inv_r        <= INV_WHEEL_BASE_RST;
      maxdt_r      <= MAX_DT_US_RST;
      prev_stamp_r <= 32'd0;
      yaw_r        <= 32'd0;
      acc_x_r      <= '0;
      acc_y_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_INV_WHEEL_BASE) begin
          inv_r <= cfg_data[23:0];
        end else if (cfg_index == CFG_MAX_DT_US) begin
          maxdt_r <= cfg_data;
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            prev_stamp_r <= in_stamp;
            dt_r         <= in_dt;
            vc_r         <= vc17[15:0];
            vneg_r       <= vc17[16];
            vmag_r       <= vc17[16] ? 17'(-vc17) : 17'(vc17);
            dneg_r       <= dif_lr[16];
            dmag_r       <= dif_lr[16] ? 17'(-dif_lr) : 17'(dif_lr);
            if (in_ok) state_r <= S_MW;
          end
        end
        S_MW: state_r <= S_MP;
        S_MP: begin
          wneg_r  <= dneg_r;
          w_r     <= dneg_r ? $signed(32'd0 - wmag_c) : $signed(wmag_c);
          state_r <= S_MYL;
        end
        S_MYL: begin
          p_hi_r  <= prod_r[63:32];
          state_r <= S_MYH;
        end
        S_MYH: begin
          rnd_r   <= 33'((prod_r + 64'h8000_0000) >> 32);
          state_r <= S_YAW;
        end
        S_YAW: begin
          mid_r   <= mid_t[32:1];
          yaw_r   <= yaw_r + dth_c[31:0];
          state_r <= S_MDL;
        end
        S_MDL: begin
          p_hi_r  <= prod_r[63:32];
          state_r <= S_MDH;
        end
        S_MDH: begin
          rnd_r   <= 33'((prod_r + 64'h8000_0000) >> 32);
          state_r <= S_ROT0;
        end
        S_ROT0: begin
          x_r     <= quad_c ? -x0_c : x0_c;
          y_r     <= 64'sd0;
          z_r     <= 34'($signed(ang_c));
          it_r    <= 5'd0;
          state_r <= S_CORD;
        end
        S_CORD: begin
          if (!z_r[33]) begin
            x_r <= x_r - cy_s;
            y_r <= y_r + cx_s;
            z_r <= z_r - $signed(34'(at_c));
          end else begin
            x_r <= x_r + cy_s;
            y_r <= y_r - cx_s;
            z_r <= z_r + $signed(34'(at_c));
          end
          it_r <= it_r + 5'd1;
          if (it_r == 5'(CORDIC_STEPS - 1)) begin
            sel_y_r <= 1'b0;
            state_r <= S_DSET;
          end
        end
        S_DSET: begin
          num_r   <= NUMW'((src_mag + DIV_HALF) >> DIV_SHIFT);
          qneg_r  <= sel_y_r ? y_r[63] : x_r[63];
          state_r <= S_QH;
        end
        S_QH: state_r <= S_RH;
        S_RH: begin
          // hold the upper quotient, carry the remainder into the lower half
          quo_hi_r <= qh_c;
          num_lo_r <= {rh_c[6:0], num_r[23:0]};
          state_r  <= S_QL;
        end
        S_QL: state_r <= S_ACC;
        S_ACC: begin
          if (sel_y_r) begin
            acc_y_r      <= sat_c[POS_WIDTH-1:0];
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {w_r, vc_r, yaw_r,
                             40'(SUMW'($signed(sat_c[POS_WIDTH-1:0]))),
                             40'(SUMW'($signed(acc_x_r)))};
            state_r      <= S_OUT;
          end else begin
            acc_x_r <= sat_c[POS_WIDTH-1:0];
            sel_y_r <= 1'b1;
            state_r <= S_DSET;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            out_tvalid_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // the core never takes a word while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input ready while result pending");

  // a rejected sample leaves the core idle
  a_reject_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_ok) |=> in_tready)
    else $error("rejected sample started work");

  // a result appears only at the end of the second divide
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == S_ACC && $past(sel_y_r)))
    else $error("result raised outside the final divide");

  // a taken result frees the input on the next cycle
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> (in_tready && !out_tvalid))
    else $error("core did not return to idle");

endmodule
